// File: hw/rtl/ppt_pkg.sv
// Peer pairing table package: field widths, frame kinds, event codes,
// slot status, queue item and back-end state types. No dependencies.
package ppt_pkg;

  localparam int ADDR_W      = 48;
  localparam int TIME_W      = 32;
  localparam int KIND_W      = 3;
  localparam int EV_W        = 3;
  localparam int SLOT_W      = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ADDR_W-1:0] BCAST_ADDR = {ADDR_W{1'b1}};

  localparam logic [KIND_W-1:0] K_HELLO         = 3'd0;
  localparam logic [KIND_W-1:0] K_ACK_HELLO     = 3'd1;
  localparam logic [KIND_W-1:0] K_ACK_CONFIRM   = 3'd2;
  localparam logic [KIND_W-1:0] K_ACK_CONNECTED = 3'd3;
  localparam logic [KIND_W-1:0] K_ALIVE         = 3'd4;

  localparam logic [EV_W-1:0] EV_IGNORED   = 3'd0;
  localparam logic [EV_W-1:0] EV_ADDED     = 3'd1;
  localparam logic [EV_W-1:0] EV_FULL      = 3'd2;
  localparam logic [EV_W-1:0] EV_LINKFAIL  = 3'd3;
  localparam logic [EV_W-1:0] EV_CONNECTED = 3'd4;
  localparam logic [EV_W-1:0] EV_REMOVED   = 3'd5;
  localparam logic [EV_W-1:0] EV_REFRESHED = 3'd6;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_DISC  = 2'd1,
    ST_ASSOC = 2'd2,
    ST_CONN  = 2'd3
  } ppt_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DRAIN,
    BK_DECIDE
  } ppt_state_t;

  typedef struct packed {
    logic              drop;
    logic              for_me;
    logic [ADDR_W-1:0] src;
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] now;
    logic              link_ok;
    logic              send_ok;
  } ppt_item_t;

endpackage

// File: hw/rtl/ppt_front.sv
// Peer pairing table front end: accepts frames, marks those that fail the length
// or destination check, and queues classified items for the back end. Uses ppt_pkg.
module ppt_front import ppt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              frame_length_ok,
  input  logic [ADDR_W-1:0] dest_address,
  input  logic [ADDR_W-1:0] source_address,
  input  logic [KIND_W-1:0] message_kind,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              link_add_ok,
  input  logic              send_ok,
  input  logic [ADDR_W-1:0] own_address,
  output logic              q_valid,
  output ppt_item_t         q_head,
  input  logic              q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ppt_item_t        fifo [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  logic             for_me;
  ppt_item_t        item;

  assign busy    = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign push    = start && !busy;
  assign pop     = q_pop && q_valid;
  assign q_head  = fifo[rd_ptr];

  // classify: drop bad length or frames for another node
  always_comb begin
    for_me       = (dest_address == own_address);
    item.drop    = !frame_length_ok || ((dest_address != BCAST_ADDR) && !for_me);
    item.for_me  = for_me;
    item.src     = source_address;
    item.kind    = message_kind;
    item.now     = now_ms;
    item.link_ok = link_add_ok;
    item.send_ok = send_ok;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/ppt_back.sv
// Peer pairing table back end: walks the slot table one slot a cycle,
// then updates slots and flags and issues the result. Uses ppt_pkg.
module ppt_back import ppt_pkg::*; #(
  parameter int PEER_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] own_address,
  input  logic              q_valid,
  input  ppt_item_t         q_head,
  output logic              q_pop,
  output logic              done,
  output logic              reply_valid,
  output logic [KIND_W-1:0] reply_kind,
  output logic [ADDR_W-1:0] reply_dest,
  output logic [SLOT_W-1:0] slot_index,
  output logic [EV_W-1:0]   event_code,
  output logic              self_is_leader,
  output logic              pairing_now
);

  localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CNT_W = $clog2(PEER_SLOTS + 1);

  logic [ADDR_W-1:0] addr_mem [PEER_SLOTS];
  logic [TIME_W-1:0] seen_mem [PEER_SLOTS];
  ppt_status_t       status   [PEER_SLOTS];

  ppt_state_t        state;
  ppt_state_t        state_next;
  ppt_item_t         cur;
  logic [CNT_W-1:0]  rp;
  logic              issue;
  logic              decide;

  logic              s_vld;
  logic [IDX_W-1:0]  s_idx;
  logic [ADDR_W-1:0] s_addr;
  ppt_status_t       s_stat;

  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic              has_free;
  logic [IDX_W-1:0]  free_idx;
  logic              lower;
  logic              pairing;
  logic              leader;

  logic              st_we;
  logic [IDX_W-1:0]  st_widx;
  ppt_status_t       st_wval;
  logic              addr_we;
  logic              seen_we;
  logic [IDX_W-1:0]  seen_widx;
  logic              pairing_next;
  logic              leader_next;
  logic              r_valid;
  logic [KIND_W-1:0] r_kind;
  logic [ADDR_W-1:0] r_dest;
  logic [IDX_W-1:0]  r_slot;
  logic [EV_W-1:0]   r_ev;
  logic [IDX_W+2:0]  slot_wide;
  logic              sent;
  logic              src_self;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = BK_WALK;
        end
      end
      BK_WALK: begin
        if (rp == CNT_W'(PEER_SLOTS - 1)) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN:  state_next = BK_DECIDE;
      BK_DECIDE: state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = (state == BK_IDLE) && q_valid;
    issue  = (state == BK_WALK);
    decide = (state == BK_DECIDE);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (issue) begin
      s_addr <= addr_mem[rp[IDX_W-1:0]];
      s_stat <= status[rp[IDX_W-1:0]];
      s_idx  <= rp[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (decide && addr_we) begin
      addr_mem[r_slot] <= cur.src;
    end
    if (decide && seen_we) begin
      seen_mem[seen_widx] <= cur.now;
    end
  end

  always_comb begin
    st_we        = 1'b0;
    st_widx      = '0;
    st_wval      = ST_EMPTY;
    addr_we      = 1'b0;
    seen_we      = 1'b0;
    seen_widx    = '0;
    pairing_next = 1'b0;
    leader_next  = leader;
    r_valid      = 1'b0;
    r_kind       = '0;
    r_dest       = '0;
    r_slot       = '0;
    r_ev         = EV_IGNORED;
    src_self     = (cur.src == own_address);
    sent         = !src_self && cur.send_ok;
    if (cur.drop) begin
      pairing_next = 1'b0;
    end else if (!hit && !pairing) begin
      if (cur.kind == K_HELLO || (cur.kind == K_ACK_HELLO && cur.for_me)) begin
        if (!has_free) begin
          pairing_next = 1'b1;
          r_ev         = EV_FULL;
        end else begin
          r_slot    = free_idx;
          addr_we   = 1'b1;
          seen_we   = 1'b1;
          seen_widx = free_idx;
          st_we     = 1'b1;
          st_widx   = free_idx;
          if (!cur.link_ok) begin
            st_wval = ST_DISC;
            r_ev    = EV_LINKFAIL;
          end else begin
            st_wval = ST_ASSOC;
            r_ev    = EV_ADDED;
            r_valid = !src_self;
            r_kind  = (cur.kind == K_HELLO) ? K_ACK_HELLO : K_ACK_CONFIRM;
            pairing_next = sent;
            if (!sent && cur.kind == K_ACK_HELLO) begin
              st_wval = ST_EMPTY;
              r_ev    = EV_REMOVED;
            end
          end
        end
      end
    end else if (cur.for_me) begin
      if (pairing) begin
        if (hit && (cur.kind == K_ACK_CONFIRM || cur.kind == K_ACK_CONNECTED)) begin
          r_slot      = hit_idx;
          st_we       = 1'b1;
          st_widx     = hit_idx;
          st_wval     = ST_CONN;
          leader_next = !(lower || (cur.src < own_address));
          r_ev        = EV_CONNECTED;
          if (cur.kind == K_ACK_CONFIRM) begin
            r_valid = !src_self;
            r_kind  = K_ACK_CONNECTED;
            if (!sent) begin
              st_wval = ST_EMPTY;
              r_ev    = EV_REMOVED;
            end
          end
        end
      end else if (cur.kind == K_ALIVE && hit) begin
        seen_we   = 1'b1;
        seen_widx = hit_idx;
        r_slot    = hit_idx;
        r_ev      = EV_REFRESHED;
      end
    end
    if (r_valid) begin
      r_dest = cur.src;
    end else begin
      r_kind = '0;
    end
  end

  assign slot_wide = {3'b000, r_slot};

  always_ff @(posedge clk) begin
    if (decide) begin
      reply_valid <= r_valid;
      reply_kind  <= r_kind;
      reply_dest  <= r_dest;
      slot_index  <= slot_wide[SLOT_W-1:0];
      event_code  <= r_ev;
    end
  end

  assign self_is_leader = leader;
  assign pairing_now    = pairing;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      rp       <= '0;
      s_vld    <= 1'b0;
      hit      <= 1'b0;
      hit_idx  <= '0;
      has_free <= 1'b0;
      free_idx <= '0;
      lower    <= 1'b0;
      pairing  <= 1'b0;
      leader   <= 1'b0;
      done     <= 1'b0;
      for (int i = 0; i < PEER_SLOTS; i++) begin
        status[i] <= ST_EMPTY;
      end
    end else begin
      state <= state_next;
      s_vld <= issue;
      done  <= decide;
      if (q_pop) begin
        rp       <= '0;
        hit      <= 1'b0;
        has_free <= 1'b0;
        lower    <= 1'b0;
      end
      if (issue) begin
        rp <= rp + 1'b1;
      end
      if (s_vld) begin
        if (!hit && s_stat != ST_EMPTY && s_addr == cur.src) begin
          hit     <= 1'b1;
          hit_idx <= s_idx;
        end
        if (!has_free && s_stat == ST_EMPTY) begin
          has_free <= 1'b1;
          free_idx <= s_idx;
        end
        if (s_stat == ST_CONN && s_addr < own_address) begin
          lower <= 1'b1;
        end
      end
      if (decide) begin
        pairing <= pairing_next;
        leader  <= leader_next;
        if (st_we) begin
          status[st_widx] <= st_wval;
        end
      end
    end
  end

endmodule

// File: hw/rtl/peer_pairing_table.sv
// Peer pairing table top level: own-address register, front end and back end.
// Depends on ppt_pkg, ppt_front and ppt_back.
// A taken start queues the item; the back end pops it, walks every slot, drains,
// decides and registers done. The back end takes one item at a time, paced by the
// one-slot-a-cycle walk of the address store; a two-item queue holds arrivals.
// Results show for one cycle on done and cannot be stalled.
// Reset (rst, synchronous) empties all slots and the queue, clears both flags and
// own_address; slot addresses and seen times stay undefined until written.
module peer_pairing_table import ppt_pkg::*; #(
  parameter int PEER_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic              frame_length_ok,
  input  logic [ADDR_W-1:0] dest_address,
  input  logic [ADDR_W-1:0] source_address,
  input  logic [KIND_W-1:0] message_kind,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              link_add_ok,
  input  logic              send_ok,
  output logic              done,
  output logic              reply_valid,
  output logic [KIND_W-1:0] reply_kind,
  output logic [ADDR_W-1:0] reply_dest,
  output logic [SLOT_W-1:0] slot_index,
  output logic [EV_W-1:0]   event_code,
  output logic              self_is_leader,
  output logic              pairing_now
);

  logic [ADDR_W-1:0] own_address;
  logic              q_valid;
  ppt_item_t         q_head;
  logic              q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      own_address <= cfg_data;
    end
  end

  ppt_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .frame_length_ok (frame_length_ok),
    .dest_address    (dest_address),
    .source_address  (source_address),
    .message_kind    (message_kind),
    .now_ms          (now_ms),
    .link_add_ok     (link_add_ok),
    .send_ok         (send_ok),
    .own_address     (own_address),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop)
  );

  ppt_back #(
    .PEER_SLOTS (PEER_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .own_address    (own_address),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .done           (done),
    .reply_valid    (reply_valid),
    .reply_kind     (reply_kind),
    .reply_dest     (reply_dest),
    .slot_index     (slot_index),
    .event_code     (event_code),
    .self_is_leader (self_is_leader),
    .pairing_now    (pairing_now)
  );

endmodule

// File: hw/rtl/ppt_checker.sv
// Port-level checks for the peer pairing table, bound to the top level.
// Depends on ppt_pkg and peer_pairing_table.
module ppt_checker import ppt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              done,
  input logic              reply_valid,
  input logic [KIND_W-1:0] reply_kind,
  input logic [ADDR_W-1:0] reply_dest,
  input logic [SLOT_W-1:0] slot_index,
  input logic [EV_W-1:0]   event_code,
  input logic              pairing_now
);

  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done asserted on consecutive cycles");

  a_no_reply_zero: assert property (@(posedge clk) disable iff (rst)
    done && !reply_valid |-> reply_kind == '0 && reply_dest == '0)
    else $error("reply fields nonzero without a reply");

  a_full_keeps_pairing: assert property (@(posedge clk) disable iff (rst)
    done && event_code == EV_FULL |-> pairing_now && slot_index == '0)
    else $error("table full item without pairing flag");

  a_reply_event: assert property (@(posedge clk) disable iff (rst)
    done && reply_valid |-> event_code == EV_ADDED || event_code == EV_CONNECTED
                            || event_code == EV_REMOVED)
    else $error("reply on an item with no slot change");

endmodule

bind peer_pairing_table ppt_checker u_ppt_checker (.*);
